>>> hw/rtl/hse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Hermite spline evaluator.
// No dependencies.
package hse_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned ACC_W   = 40;
	localparam logic [POS_W-1:0] T_ONE = 17'h10000;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_EVAL   = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_POINT = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] HSTEP_C = 2'd0;
	localparam logic [1:0] HSTEP_B = 2'd1;
	localparam logic [1:0] HSTEP_A = 2'd2;

	typedef struct packed {
		logic                       command;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic signed [COORD_W-1:0]  point_z;
		logic        [POS_W-1:0]    curve_position;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  curve_x;
		logic signed [COORD_W-1:0]  curve_y;
		logic signed [COORD_W-1:0]  curve_z;
		logic        [1:0]          status;
	} out_t;

	typedef struct packed {
		logic       wr_en;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       d0_zero;
		logic       d1_zero;
		logic       coef_en;
		logic       horner_en;
		logic [1:0] horner_step;
	} lane_ctrl_t;

endpackage

>>> hw/rtl/hse_lane.sv
`timescale 1ns / 1ps
// One axis lane: point memory, neighbour capture, coefficients, Horner unit.
// Depends on hse_pkg.
module hse_lane #(
	parameter int unsigned MAX_POINTS = 64,
	parameter int unsigned IW = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hse_pkg::lane_ctrl_t               ctrl,
	input  logic [IW-1:0]                     addr,
	input  logic signed [hse_pkg::COORD_W-1:0] wr_data,
	input  logic [hse_pkg::POS_W-1:0]         frac,
	output logic signed [hse_pkg::ACC_W-1:0]  acc,
	output logic signed [hse_pkg::COORD_W-1:0] p0
);
	import hse_pkg::*;

	localparam int unsigned PW = ACC_W + POS_W + 1;

	logic signed [COORD_W-1:0] mem [MAX_POINTS];
	logic signed [COORD_W-1:0] rd_data_q;
	logic [1:0]                rd_sel_q;
	logic                      rd_vld_q;
	logic signed [COORD_W-1:0] pt_q [4];
	logic signed [ACC_W-1:0]   a2_q, b2_q, c2_q, acc_q;
	logic signed [ACC_W-1:0]   pm1_w, p0_w, p1_w, p2_w, d0, d1;
	logic signed [ACC_W-1:0]   addend;
	logic signed [PW-1:0]      prod, prod_rnd;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			rd_sel_q <= 2'd0;
		end else begin
			rd_vld_q <= ctrl.rd_en;
			rd_sel_q <= ctrl.rd_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			pt_q[rd_sel_q] <= rd_data_q;
		end
	end

	always_comb begin
		pm1_w = ACC_W'(pt_q[0]);
		p0_w  = ACC_W'(pt_q[1]);
		p1_w  = ACC_W'(pt_q[2]);
		p2_w  = ACC_W'(pt_q[3]);
		d0    = ctrl.d0_zero ? '0 : p1_w - pm1_w;
		d1    = ctrl.d1_zero ? '0 : p2_w - p0_w;
	end

	always_comb begin
		case (ctrl.horner_step)
			HSTEP_C: addend = c2_q;
			HSTEP_B: addend = b2_q;
			HSTEP_A: addend = a2_q;
			default: addend = a2_q;
		endcase
		prod     = PW'(acc_q) * PW'($signed({1'b0, frac}));
		prod_rnd = (prod + PW'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (ctrl.coef_en) begin
			a2_q  <= p0_w <<< 1;
			b2_q  <= d0;
			c2_q  <= (p1_w - p0_w) * ACC_W'(6) - (d0 <<< 1) - d1;
			acc_q <= ((p0_w - p1_w) <<< 2) + d0 + d1;
		end else if (ctrl.horner_en) begin
			acc_q <= addend + ACC_W'(prod_rnd);
		end
	end

	assign acc = acc_q;
	assign p0  = pt_q[1];

endmodule

>>> hw/rtl/hse_merge.sv
`timescale 1ns / 1ps
// Merge of the three lane results: halving, saturation, single-point pass-through, status and zeroing.
// Depends on hse_pkg.
module hse_merge (
	input  logic signed [hse_pkg::ACC_W-1:0]   acc_x,
	input  logic signed [hse_pkg::ACC_W-1:0]   acc_y,
	input  logic signed [hse_pkg::ACC_W-1:0]   acc_z,
	input  logic signed [hse_pkg::COORD_W-1:0] p0_x,
	input  logic signed [hse_pkg::COORD_W-1:0] p0_y,
	input  logic signed [hse_pkg::COORD_W-1:0] p0_z,
	input  logic                               single,
	input  logic                               zero,
	input  logic [1:0]                         status,
	output hse_pkg::out_t                      res
);
	import hse_pkg::*;

	function automatic logic signed [COORD_W-1:0] fin(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] v;
		v = (a + ACC_W'(1)) >>> 1;
		if (v > ACC_W'(64'sh7FFF_FFFF)) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -ACC_W'(64'sh8000_0000)) begin
			return 32'sh8000_0000;
		end
		return v[COORD_W-1:0];
	endfunction

	always_comb begin
		res.status = status;
		if (zero) begin
			res.curve_x = '0;
			res.curve_y = '0;
			res.curve_z = '0;
		end else if (single) begin
			res.curve_x = p0_x;
			res.curve_y = p0_y;
			res.curve_z = p0_z;
		end else begin
			res.curve_x = fin(acc_x);
			res.curve_y = fin(acc_y);
			res.curve_z = fin(acc_z);
		end
	end

endmodule

>>> hw/rtl/hermite_spline_3d_evaluator_core.sv
`timescale 1ns / 1ps
// Hermite spline evaluator, top level: sequencer, three axis lanes and merge.
// Depends on hse_pkg, hse_lane, hse_merge.
// Append and errors: accept, then result. Evaluate: steps in order (segment multiply,
// four point reads on the single lane memory port, capture, coefficients,
// three Horner steps, merge). One transaction at a time.
// Reset empties the store (count to zero); memories are not cleared.
module hermite_spline_3d_evaluator_core #(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hse_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hse_pkg::out_t  out_data
);
	import hse_pkg::*;

	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned IW = $clog2(MAX_POINTS);
	localparam int unsigned GW = POS_W + CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEG  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CAP  = 3'd3;
	localparam logic [2:0] S_COEF = 3'd4;
	localparam logic [2:0] S_HORN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic [GW-1:0]    g_s1;
	logic             tone_s1;
	logic [IW-1:0]    seg_q;
	logic [POS_W-1:0] f_q;
	logic             single_q, zero_q, d0z_q, d1z_q;
	logic [1:0]       k_q, status_q;
	out_t             out_q;
	logic             out_vld_q;
	lane_ctrl_t       ctrl;
	logic [IW-1:0]    addr;
	logic             in_acc, full;
	logic [CW-1:0]    cnt_m1;
	logic signed [ACC_W-1:0]   acc_x, acc_y, acc_z;
	logic signed [COORD_W-1:0] p0_x, p0_y, p0_z;
	out_t             merged;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign full     = (cnt_q >= CW'(MAX_POINTS));
	assign cnt_m1   = cnt_q - CW'(1);

	always_comb begin
		ctrl             = '0;
		ctrl.wr_en       = in_acc && (in_data.command == CMD_APPEND) && !full;
		ctrl.rd_en       = (state_q == S_RD);
		ctrl.rd_sel      = k_q;
		ctrl.d0_zero     = d0z_q;
		ctrl.d1_zero     = d1z_q;
		ctrl.coef_en     = (state_q == S_COEF);
		ctrl.horner_en   = (state_q == S_HORN);
		ctrl.horner_step = k_q;
		if (state_q == S_RD) begin
			addr = seg_q + IW'(k_q) - IW'(1);
		end else begin
			addr = cnt_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
			status_q  <= ST_OK;
			zero_q    <= 1'b0;
			single_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_vld_q || out_ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						single_q <= 1'b0;
						zero_q   <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						if (in_data.command == CMD_APPEND) begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (cnt_q == '0) begin
							status_q <= ST_NO_POINT;
						end else if (in_data.curve_position > T_ONE) begin
							status_q <= ST_RANGE;
						end else begin
							zero_q   <= 1'b0;
							single_q <= (cnt_q == CW'(1));
							state_q  <= S_SEG;
						end
					end
				end
				S_SEG: begin
					k_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= S_CAP;
					end
				end
				S_CAP: state_q <= S_COEF;
				S_COEF: begin
					k_q     <= HSTEP_C;
					state_q <= S_HORN;
				end
				S_HORN: begin
					k_q <= k_q + 2'd1;
					if (k_q == HSTEP_A) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_vld_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			g_s1    <= GW'(in_data.curve_position) * GW'(cnt_m1);
			tone_s1 <= (in_data.curve_position == T_ONE);
		end
		if (state_q == S_SEG) begin
			if (single_q) begin
				seg_q <= '0;
				f_q   <= '0;
				d0z_q <= 1'b1;
				d1z_q <= 1'b1;
			end else if (tone_s1) begin
				seg_q <= IW'(cnt_m1 - CW'(1));
				f_q   <= T_ONE;
				d0z_q <= (cnt_m1 == CW'(1));
				d1z_q <= 1'b1;
			end else begin
				seg_q <= IW'(g_s1 >> 16);
				f_q   <= {1'b0, g_s1[15:0]};
				d0z_q <= (g_s1[GW-1:16] == '0);
				d1z_q <= ((g_s1[GW-1:16] + (GW-16)'(2)) == (GW-16)'(cnt_q));
			end
		end
		if (state_q == S_DONE && (!out_vld_q || out_ready)) begin
			out_q <= merged;
		end
	end

	hse_lane #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .addr(addr),
		.wr_data(in_data.point_x), .frac(f_q), .acc(acc_x), .p0(p0_x)
	);
	hse_lane #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .addr(addr),
		.wr_data(in_data.point_y), .frac(f_q), .acc(acc_y), .p0(p0_y)
	);
	hse_lane #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .addr(addr),
		.wr_data(in_data.point_z), .frac(f_q), .acc(acc_z), .p0(p0_z)
	);

	hse_merge u_merge (
		.acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
		.single(single_q), .zero(zero_q), .status(status_q), .res(merged)
	);

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count above capacity");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.command == CMD_APPEND && full) |=> $stable(cnt_q))
		else $error("count moved on dropped point");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.status != ST_OK) |->
		(out_q.curve_x == '0 && out_q.curve_y == '0 && out_q.curve_z == '0))
		else $error("non-zero result with error status");

endmodule
